[sv/wsts_pkg.sv]
package wsts_pkg;
  localparam int BRANCH_DEF = 16;
  localparam int LEVELS_DEF = 3;
  localparam int RATE_BITS_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int INDEX_BITS = 12;
  localparam int TOTAL_BITS = 44;
  localparam int LEAF_COUNT = 4096;
  localparam int MID_COUNT = 256;
  localparam int UP_COUNT = 16;
  localparam int CHILD_BITS = 4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Datapath commands from the controller
  typedef struct packed {
    logic clr;
    logic load;
    logic leaf_wr;
    logic sum_clr;
    logic sum_acc;
    logic mid_wr;
    logic up_wr;
    logic tot_wr;
    logic [1:0] lvl;
    logic sel_init;
    logic sel_acc;
    logic sel_pick;
    logic res_fire;
    logic [CHILD_BITS-1:0] k;
  } wsts_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mode;
    logic tot_zero;
    logic found;
  } wsts_sts_t;
endpackage

[sv/wsts_datapath.sv]
module wsts_datapath
  import wsts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsts_cmd_t             cmd,
  output wsts_sts_t             sts,
  input  logic                  in_mode,
  input  logic [INDEX_BITS-1:0] in_entry_index,
  input  logic [31:0]           in_rate,
  input  logic [47:0]           in_random_word,
  output logic                  out_strobe,
  output logic [INDEX_BITS-1:0] out_selected_index,
  output logic                  out_none_available,
  output logic [TOTAL_BITS-1:0] out_total_rate
);
  // Tree storage: leaf and middle sums in memories, upper sums in flops
  logic [31:0] leaf_mem [LEAF_COUNT];
  logic [35:0] mid_mem [MID_COUNT];
  logic [39:0] up_r [UP_COUNT];
  logic [TOTAL_BITS-1:0] total_r;
  logic [11:0] clr_addr_r;

  logic        mode_r;
  logic [11:0] idx_r;
  logic [31:0] rate_r;
  logic [47:0] rnd_r;
  logic [43:0] acc_r, acc_nxt;
  logic [43:0] node_r, sel_r, pick_val_r;
  logic [11:0] base_r;
  logic [3:0]  pick_k_r;
  logic        found_r;
  logic [31:0] leaf_q_r;
  logic [35:0] mid_q_r;

  // Child read address per level
  logic [11:0] leaf_addr;
  logic [7:0]  mid_addr;
  logic [3:0]  rd_k_r;
  logic [1:0]  rd_lvl_r;
  logic        rd_sel_r, rd_sum_r;
  assign leaf_addr = (mode_r == MODE_WRITE) ? {idx_r[11:4], cmd.k} : {base_r[7:0], cmd.k};
  assign mid_addr  = (mode_r == MODE_WRITE) ? {idx_r[11:8], cmd.k} : {base_r[3:0], cmd.k};

  // Memory ports; the clearing pass after reset zeroes one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr) leaf_mem[clr_addr_r] <= '0;
    else if (cmd.leaf_wr) leaf_mem[idx_r] <= rate_r;
    leaf_q_r <= leaf_mem[leaf_addr];
    if (cmd.clr) mid_mem[clr_addr_r[7:0]] <= '0;
    else if (cmd.mid_wr) mid_mem[idx_r[11:4]] <= acc_r[35:0];
    mid_q_r <= mid_mem[mid_addr];
  end

  // Child value, arriving in the cycle after the command
  logic [43:0] child;
  always_comb begin
    unique case (rd_lvl_r)
      2'd0:    child = {4'd0, up_r[rd_k_r]};
      2'd1:    child = {8'd0, mid_q_r};
      default: child = {12'd0, leaf_q_r};
    endcase
  end
  assign acc_nxt = acc_r + child;

  // Selector fraction per level
  logic [15:0] frac;
  always_comb begin
    unique case (cmd.lvl)
      2'd0:    frac = rnd_r[47:32];
      2'd1:    frac = rnd_r[31:16];
      default: frac = rnd_r[15:0];
    endcase
  end
  logic [59:0] prod;
  assign prod = {16'd0, node_r} * {44'd0, frac};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < UP_COUNT; i++) up_r[i] <= '0;
      clr_addr_r <= '0;
      out_strobe <= 1'b0;
      rd_sel_r <= 1'b0;
      rd_sum_r <= 1'b0;
    end else begin
      out_strobe <= cmd.res_fire;
      rd_sel_r <= cmd.sel_acc;
      rd_sum_r <= cmd.sum_acc;
      if (cmd.clr) clr_addr_r <= clr_addr_r + 12'd1;
      if (cmd.up_wr) up_r[idx_r[11:8]] <= acc_r[39:0];
      if (cmd.tot_wr) total_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r <= cmd.k;
    rd_lvl_r <= cmd.lvl;
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r <= in_entry_index;
      rate_r <= in_rate;
      rnd_r <= in_random_word;
      base_r <= '0;
    end
    if (cmd.sum_clr) acc_r <= '0;
    else if (rd_sum_r || rd_sel_r) acc_r <= acc_nxt;
    // Start a level: selector and clear scan
    if (cmd.sel_init) begin
      if (cmd.lvl == 2'd0) node_r <= total_r;
      sel_r <= prod[59:16];
      found_r <= 1'b0;
      pick_k_r <= 4'd15;
    end
    if (rd_sel_r && !found_r) begin
      pick_val_r <= child;
      pick_k_r <= rd_k_r;
      if (sel_r < acc_nxt) found_r <= 1'b1;
    end
    if (cmd.sel_pick) begin
      node_r <= pick_val_r;
      base_r <= {base_r[7:0], pick_k_r};
    end
  end
  // node_r for level 0 must be valid before product: sel_init is issued twice
  assign sts.clr_last = (clr_addr_r == 12'hFFF);
  assign sts.mode = mode_r;
  assign sts.tot_zero = (total_r == '0);
  assign sts.found = found_r;

  always_ff @(posedge clk) begin
    if (cmd.res_fire) begin
      out_selected_index <= (mode_r == MODE_SELECT && total_r != '0) ? base_r : '0;
      out_none_available <= (mode_r == MODE_SELECT) && (total_r == '0);
      out_total_rate <= total_r;
    end
  end
endmodule

[sv/wsts_ctrl.sv]
module wsts_ctrl
  import wsts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  wsts_sts_t sts,
  output wsts_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_WLEAF = 4'd2, S_WSUM = 4'd3,
    S_WEND = 4'd4, S_SNODE = 4'd5, S_SINIT = 4'd6, S_SSCAN = 4'd7, S_SDRAIN = 4'd8,
    S_SPICK = 4'd9, S_RES = 4'd10, S_CLR = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [4:0] k_r, k_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lvl_nxt = lvl_r;
    k_nxt = k_r;
    cmd = '0;
    cmd.lvl = lvl_r;
    cmd.k = k_r[3:0];
    unique case (state_r)
      // Zero the tree memories after reset, one entry a cycle
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.mode == MODE_WRITE) begin
          state_nxt = S_WLEAF;
        end else if (sts.tot_zero) begin
          state_nxt = S_RES;
        end else begin
          lvl_nxt = 2'd0;
          state_nxt = S_SNODE;
        end
      end
      S_WLEAF: begin
        cmd.leaf_wr = 1'b1;
        cmd.sum_clr = 1'b1;
        lvl_nxt = 2'd2;
        k_nxt = '0;
        state_nxt = S_WSUM;
      end
      // Sum 16 children of the current level, one a cycle
      S_WSUM: begin
        if (k_r[4]) begin
          state_nxt = S_WEND;
        end else begin
          cmd.sum_acc = 1'b1;
          k_nxt = k_r + 5'd1;
        end
      end
      S_WEND: begin
        cmd.sum_clr = 1'b1;
        k_nxt = '0;
        unique case (lvl_r)
          2'd2: begin cmd.mid_wr = 1'b1; lvl_nxt = 2'd1; state_nxt = S_WSUM; end
          2'd1: begin cmd.up_wr = 1'b1; lvl_nxt = 2'd0; state_nxt = S_WSUM; end
          default: begin cmd.tot_wr = 1'b1; state_nxt = S_RES; end
        endcase
      end
      S_SNODE: begin
        cmd.sel_init = 1'b1;
        state_nxt = S_SINIT;
      end
      S_SINIT: begin
        cmd.sel_init = 1'b1;
        cmd.sum_clr = 1'b1;
        k_nxt = '0;
        state_nxt = S_SSCAN;
      end
      S_SSCAN: begin
        if (k_r[4]) state_nxt = S_SDRAIN;
        else begin
          cmd.sel_acc = 1'b1;
          k_nxt = k_r + 5'd1;
        end
      end
      S_SDRAIN: state_nxt = S_SPICK;
      S_SPICK: begin
        cmd.sel_pick = 1'b1;
        if (lvl_r == 2'd2) state_nxt = S_RES;
        else begin
          lvl_nxt = lvl_r + 2'd1;
          state_nxt = S_SNODE;
        end
      end
      S_RES: begin
        cmd.res_fire = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      lvl_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r <= lvl_nxt;
      k_r <= k_nxt;
    end
  end

  a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_fire |=> !cmd.res_fire) else $error("double result");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_fire |-> busy) else $error("result while idle");
  a_no_wr_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.leaf_wr || cmd.tot_wr) |-> !cmd.sel_acc) else $error("mixed cmds");
endmodule

[sv/weighted_sum_tree_sampler.sv]
// Weighted sum-tree sampler over 4096 leaf rates (16-ary, three levels).
// start is taken when busy is low; one result per item is shown on the out_
// ports for a single cycle with out_valid and cannot be stalled. After start
// is taken busy stays high through a write (three 16-child summing passes
// through the tree memories), a select (three 16-child prefix scans) or a
// select of an empty tree (no scan); the result appears in the cycle in
// which busy drops. After reset busy stays high while the leaf and middle
// memories are cleared.
module weighted_sum_tree_sampler
  import wsts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [INDEX_BITS-1:0] in_entry_index,
  input  logic [31:0]           in_rate,
  input  logic [47:0]           in_random_word,
  output logic                  out_valid,
  output logic [INDEX_BITS-1:0] out_selected_index,
  output logic                  out_none_available,
  output logic [TOTAL_BITS-1:0] out_total_rate
);
  wsts_cmd_t cmd;
  wsts_sts_t sts;

  wsts_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);
  wsts_datapath u_dp (.clk, .rst_n, .cmd, .sts, .in_mode, .in_entry_index,
    .in_rate, .in_random_word, .out_strobe(out_valid), .out_selected_index,
    .out_none_available, .out_total_rate);
endmodule
